>>> hw/rtl/pwmcap_pkg.sv
// Shared widths, reset values and codes of the PWM capture meter.
package pwmcap_pkg;

	localparam int CNT_W     = 32;
	localparam int CH_W      = 3;
	localparam int PIN_W     = 6;
	localparam int PIN_SPAN  = 2 ** CH_W;
	localparam int DUTY_W    = 7;
	localparam int NUM_W     = CNT_W + DUTY_W;
	localparam int CFG_IDX_W = 2;
	localparam int STATUS_W  = 2;
	localparam int CHANNELS  = 6;
	localparam int TIMEOUT_DIV = 20;

	localparam logic [DUTY_W-1:0] DUTY_SCALE    = 7'd100;
	localparam logic [CNT_W-1:0]  TICK_RATE_RST = 32'd50000000;
	localparam logic [CNT_W-1:0]  TIMEOUT_RST   = TICK_RATE_RST / TIMEOUT_DIV;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TICK_RATE = 2'd0,
		REG_TIMEOUT   = 2'd1
	} cfg_reg_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_MEASURED    = 2'd0,
		ST_TIMEOUT     = 2'd1,
		ST_ZERO_PERIOD = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_DIFF,
		SQ_WRAP,
		SQ_MAG,
		SQ_MUL,
		SQ_SORT,
		SQ_FREQ,
		SQ_DUTY
	} seq_state_t;

endpackage

>>> hw/rtl/pwmcap_if.sv
// Handshake channels of the PWM capture meter: tick input, result output, config writes.
interface pwmcap_tick_if import pwmcap_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              start_req;
	logic [CH_W-1:0]   channel;
	logic [PIN_W-1:0]  pin_levels;

	modport source (output valid, start_req, channel, pin_levels, input ready);
	modport sink   (input valid, start_req, channel, pin_levels, output ready);
endinterface

interface pwmcap_result_if import pwmcap_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CH_W-1:0]     result_channel;
	logic [STATUS_W-1:0] status;
	logic [CNT_W-1:0]    frequency;
	logic [DUTY_W-1:0]   duty_percent;

	modport source (output valid, result_channel, status, frequency, duty_percent,
		input ready);
	modport sink   (input valid, result_channel, status, frequency, duty_percent,
		output ready);
endinterface

interface pwmcap_cfg_if import pwmcap_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] reg_index;
	logic [CNT_W-1:0]     data;

	modport source (output valid, reg_index, data, input ready);
	modport sink   (input valid, reg_index, data, output ready);
endinterface

>>> hw/rtl/pwmcap_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module pwmcap_div import pwmcap_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic             done,
	output logic [NUM_W-1:0] quotient
);

	localparam int STEP_W = $clog2(NUM_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] steps_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dsr_q;
	logic [NUM_W-1:0]  dq_q;   // dividend shifts out the top, quotient in at the bottom
	logic [CNT_W:0]    trial;
	logic [CNT_W+1:0]  diff;
	logic              fits;

	always_comb begin
		trial = {rem_q, dq_q[NUM_W-1]};
		diff  = {1'b0, trial} - {2'b0, dsr_q};
		fits  = !diff[CNT_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			steps_q <= '0;
		end else begin
			done_q <= busy_q && (steps_q == STEP_W'(1));
			if (start) begin
				busy_q  <= 1'b1;
				steps_q <= STEP_W'(NUM_W);
			end else if (busy_q) begin
				steps_q <= steps_q - STEP_W'(1);
				if (steps_q == STEP_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			dq_q  <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			dq_q  <= {dq_q[NUM_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

>>> hw/rtl/pwm_input_capture_meter_top.sv
// Top level of the PWM input capture meter: edge capture, span math and serial division.
//
//  channel  dir  handshake       payload
//  -------  ---  --------------  ----------------------------------------------------
//  tick     in   valid / ready   start_req, channel[2:0], pin_levels[5:0]
//  result   out  valid / ready   result_channel[2:0], status[1:0], frequency[31:0],
//                                duty_percent[6:0]
//  cfg      in   valid / ready   reg_index[1:0], data[31:0]  (0 tick_rate, 1 timeout_ticks)
//
// A tick that completes a measurement on its second rising edge hands off to a sequencer:
// span and scale math in the states DIFF, WRAP, MAG, MUL and SORT, then two serial
// divisions (frequency, then duty); tick.ready is low meanwhile.
// A zero period or a wrapped-negative period skips the divisions.
// A timeout result is loaded straight into the output register on its tick.
// While a measurement runs and the output register still holds an untaken result,
// ticks stall; with no measurement running and the sequencer idle, ticks flow regardless of result.ready.
// Reset (arst_n low) clears the counter, the measurement state and the config to defaults.
module pwm_input_capture_meter_top import pwmcap_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	pwmcap_tick_if.sink     tick,
	pwmcap_result_if.source result,
	pwmcap_cfg_if.sink      cfg
);

	// configuration
	logic [CNT_W-1:0] tick_rate_q;
	logic [CNT_W-1:0] timeout_q;

	// measurement state
	logic [CNT_W-1:0] cnt_q;
	logic             prev_q;
	logic             meas_q;
	logic [CH_W-1:0]  act_q;
	logic [1:0]       rises_q;
	logic [CNT_W-1:0] ear_q;
	logic [CNT_W-1:0] lat_q;
	logic [CNT_W-1:0] fall_q;
	logic [CNT_W-1:0] elapsed_q;

	// sequencer datapath
	seq_state_t       state_q, state_d;
	logic [CNT_W:0]   dp_q, dh_q;        // raw stamp differences with borrow
	logic [CNT_W-1:0] p_q, h_q;          // low word of wrap-corrected spans
	logic             pneg_q, hneg_q;    // span went negative (stale stamp past tick_rate)
	logic [CNT_W-1:0] pmag_q, hmag_q;
	logic [NUM_W-1:0] num_q;             // 100 * |high|
	logic [CNT_W-1:0] freq_q;

	// output register
	logic                out_valid_q;
	logic [CH_W-1:0]     res_ch_q;
	status_t             res_status_q;
	logic [CNT_W-1:0]    res_freq_q;
	logic [DUTY_W-1:0]   res_duty_q;

	logic                out_load;
	status_t             out_status_d;
	logic [CNT_W-1:0]    out_freq_d;
	logic [DUTY_W-1:0]   out_duty_d;

	// divider hookup
	logic             div_start;
	logic [NUM_W-1:0] div_dividend;
	logic             div_done;
	logic [NUM_W-1:0] quot;

	// tick-side combinational signals
	logic                tick_fire;
	logic                seq_busy;
	logic                slot_free;
	logic [PIN_SPAN-1:0] pins_ext;
	logic                start_ok;
	logic                start_lvl;
	logic                lvl;
	logic                rise;
	logic                fall;
	logic [1:0]          rise_nx;
	logic [CNT_W-1:0]    elapsed_nx;
	logic                timed_out;
	logic [CNT_W:0]      cnt_inc;
	logic [CNT_W-1:0]    cnt_nx;
	logic [CNT_W:0]      p_sum, h_sum;

	// ---------------- handshakes ----------------
	assign seq_busy  = (state_q != SQ_IDLE);
	assign slot_free = !out_valid_q || result.ready;
	// a tick can only produce a result while measuring, so only then must the slot be free
	assign tick.ready = !seq_busy && (slot_free || !meas_q);
	assign tick_fire  = tick.valid && tick.ready;
	assign cfg.ready  = 1'b1;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_rate_q <= TICK_RATE_RST;
			timeout_q   <= TIMEOUT_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_reg_t'(cfg.reg_index))
				REG_TICK_RATE: tick_rate_q <= cfg.data;
				REG_TIMEOUT:   timeout_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	// ---------------- edge capture ----------------
	always_comb begin
		pins_ext   = PIN_SPAN'(tick.pin_levels);   // missing pins read low
		start_ok   = tick.start_req && (int'(tick.channel) < CHANNELS);
		start_lvl  = pins_ext[tick.channel];
		lvl        = pins_ext[act_q];
		rise       = !prev_q && lvl;
		fall       = prev_q && !lvl;
		rise_nx    = (rise && rises_q != 2'd3) ? rises_q + 2'd1 : rises_q;
		elapsed_nx = (&elapsed_q) ? elapsed_q : elapsed_q + CNT_W'(1);
		timed_out  = (elapsed_nx >= timeout_q);
		// counter wraps at tick_rate; also recovers from a counter left above a lowered rate
		cnt_inc    = {1'b0, cnt_q} + (CNT_W+1)'(1);
		cnt_nx     = (cnt_inc >= {1'b0, tick_rate_q}) ? '0 : cnt_inc[CNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			prev_q    <= 1'b0;
			meas_q    <= 1'b0;
			act_q     <= '0;
			rises_q   <= '0;
			ear_q     <= '0;
			lat_q     <= '0;
			fall_q    <= '0;
			elapsed_q <= '0;
		end else if (tick_fire) begin
			cnt_q <= cnt_nx;
			if (start_ok) begin
				// new measurement: no edge detection and no timeout count on this tick
				meas_q    <= 1'b1;
				act_q     <= tick.channel;
				rises_q   <= '0;
				ear_q     <= '0;
				lat_q     <= '0;
				fall_q    <= '0;
				elapsed_q <= '0;
				prev_q    <= start_lvl;
			end else if (meas_q) begin
				if (rise) begin
					ear_q <= lat_q;
					lat_q <= cnt_q;
				end else if (fall) begin
					fall_q <= cnt_q;
				end
				rises_q   <= rise_nx;
				prev_q    <= lvl;
				elapsed_q <= elapsed_nx;
				if (timed_out || rise_nx[1])
					meas_q <= 1'b0;
			end
		end
	end

	// ---------------- post-processing sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= SQ_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d      = state_q;
		div_start    = 1'b0;
		div_dividend = num_q;
		out_load     = 1'b0;
		out_status_d = ST_TIMEOUT;
		out_freq_d   = '0;
		out_duty_d   = '0;
		unique case (state_q)
			SQ_IDLE: begin
				if (tick_fire && meas_q && !start_ok) begin
					// a timeout beats the rising edge that would complete the measurement on the same tick
					if (timed_out)
						out_load = 1'b1;
					else if (rise_nx[1])
						state_d = SQ_DIFF;
				end
			end
			SQ_DIFF: state_d = SQ_WRAP;
			SQ_WRAP: state_d = SQ_MAG;
			SQ_MAG:  state_d = SQ_MUL;
			SQ_MUL:  state_d = SQ_SORT;
			SQ_SORT: begin
				if (!pneg_q && pmag_q == '0) begin
					out_load     = 1'b1;
					out_status_d = ST_ZERO_PERIOD;
					state_d      = SQ_IDLE;
				end else if (pneg_q) begin
					// huge period: frequency 0, duty is 0 or 1 by magnitude compare
					out_load     = 1'b1;
					out_status_d = ST_MEASURED;
					out_duty_d   = (hneg_q && num_q <= NUM_W'(pmag_q)) ? DUTY_W'(1) : '0;
					state_d      = SQ_IDLE;
				end else begin
					div_start    = 1'b1;
					div_dividend = NUM_W'(tick_rate_q);
					state_d      = SQ_FREQ;
				end
			end
			SQ_FREQ: begin
				if (div_done) begin
					div_start = 1'b1;
					state_d   = SQ_DUTY;
				end
			end
			SQ_DUTY: begin
				if (div_done) begin
					out_load     = 1'b1;
					out_status_d = ST_MEASURED;
					out_freq_d   = freq_q;
					// a negative high time over a positive period saturates
					out_duty_d   = (hneg_q || quot > NUM_W'(DUTY_SCALE)) ?
						DUTY_SCALE : quot[DUTY_W-1:0];
					state_d      = SQ_IDLE;
				end
			end
		endcase
	end

	// wrap correction: a borrowed difference gets tick_rate added back
	always_comb begin
		p_sum = {1'b0, dp_q[CNT_W-1:0]} + {1'b0, tick_rate_q};
		h_sum = {1'b0, dh_q[CNT_W-1:0]} + {1'b0, tick_rate_q};
	end

	always_ff @(posedge clk) begin
		if (state_q == SQ_DIFF) begin
			dp_q <= {1'b0, lat_q} - {1'b0, ear_q};
			dh_q <= {1'b0, fall_q} - {1'b0, ear_q};
		end
		if (state_q == SQ_WRAP) begin
			p_q    <= dp_q[CNT_W] ? p_sum[CNT_W-1:0] : dp_q[CNT_W-1:0];
			pneg_q <= dp_q[CNT_W] && !p_sum[CNT_W];
			h_q    <= dh_q[CNT_W] ? h_sum[CNT_W-1:0] : dh_q[CNT_W-1:0];
			hneg_q <= dh_q[CNT_W] && !h_sum[CNT_W];
		end
		if (state_q == SQ_MAG) begin
			pmag_q <= pneg_q ? -p_q : p_q;
			hmag_q <= hneg_q ? -h_q : h_q;
		end
		if (state_q == SQ_MUL)
			num_q <= NUM_W'(hmag_q) * NUM_W'(DUTY_SCALE);
		if (state_q == SQ_FREQ && div_done)
			freq_q <= quot[CNT_W-1:0];
	end

	pwmcap_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (pmag_q),
		.done     (div_done),
		.quotient (quot)
	);

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_ch_q     <= act_q;
			res_status_q <= out_status_d;
			res_freq_q   <= out_freq_d;
			res_duty_q   <= out_duty_d;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.result_channel = res_ch_q;
	assign result.status         = res_status_q;
	assign result.frequency      = res_freq_q;
	assign result.duty_percent   = res_duty_q;

endmodule

>>> hw/rtl/pwmcap_chk.sv
// Port-level checks on the result channel of the PWM capture meter, bound to the top level.
module pwmcap_chk import pwmcap_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                res_valid,
	input logic                res_ready,
	input logic [CH_W-1:0]     res_channel,
	input logic [STATUS_W-1:0] res_status,
	input logic [CNT_W-1:0]    res_frequency,
	input logic [DUTY_W-1:0]   res_duty
);

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result request dropped while stalled");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status != ST_MEASURED |-> res_frequency == '0 && res_duty == '0)
		else $error("failed measurement carries nonzero frequency or duty");

	a_duty_max: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_duty <= DUTY_SCALE)
		else $error("duty above saturation limit");

	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> int'(res_channel) < CHANNELS)
		else $error("result names a channel that cannot be started");

endmodule

bind pwm_input_capture_meter_top pwmcap_chk u_pwmcap_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (result.valid),
	.res_ready     (result.ready),
	.res_channel   (result.result_channel),
	.res_status    (result.status),
	.res_frequency (result.frequency),
	.res_duty      (result.duty_percent)
);
